// File: rtl/pwa_pkg.sv
`timescale 1ns / 1ps
package pwa_pkg;

    localparam int MAX_CHANNELS = 4;
    localparam int CHANNEL_BITS = 8;
    localparam int NUM_BITS     = 2 * CHANNEL_BITS + 1;
    localparam int STEP_BITS    = 3;

    // configuration register indexes
    localparam logic [2:0] REG_NORMALIZE_ENABLE  = 3'd0;
    localparam logic [2:0] REG_BRIGHTNESS_OFFSET = 3'd1;
    localparam logic [2:0] REG_COLOR_MODEL       = 3'd2;
    localparam logic [2:0] REG_CHANNEL_LOWS      = 3'd3;
    localparam logic [2:0] REG_CHANNEL_HIGHS     = 3'd4;
    localparam logic [2:0] REG_CHANNEL_COUNT     = 3'd5;

    localparam logic [1:0] MODEL_HSV = 2'd0;
    localparam logic [1:0] MODEL_HSL = 2'd1;

    localparam logic [0:0] REQ_MEASURE = 1'b0;
    localparam logic [0:0] REQ_APPLY   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } pwa_state_t;

    typedef struct packed {
        logic                 measure;
        logic                 first;
        logic                 load;
        logic                 mul;
        logic                 div;
        logic [STEP_BITS-1:0] step;
    } pwa_ctrl_t;

endpackage

// File: rtl/pwa_lane.sv
`timescale 1ns / 1ps
module pwa_lane (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pwa_pkg::pwa_ctrl_t    ctrl,
    input  logic [7:0]            pix,
    input  logic [7:0]            lo,
    input  logic [7:0]            hi,
    input  logic                  normalize,
    input  logic signed [8:0]     offset,
    input  logic                  bright_en,
    input  logic                  lane_en,
    output logic [7:0]            result
);

    logic [7:0] min_reg, min_next;
    logic [7:0] max_reg, max_next;
    logic [7:0] dmin_reg, a_reg, d_reg, span_reg, win_reg, quo_reg;
    logic       flat_reg;
    logic [pwa_pkg::NUM_BITS-1:0] num_reg;

    logic [7:0]  dmin, dmax, vc, win;
    logic [15:0] prod;
    logic [pwa_pkg::NUM_BITS-1:0] shifted;
    logic [7:0]  v;
    logic signed [10:0] sum;

    // running frame extremes
    always_comb begin
        min_next = min_reg;
        max_next = max_reg;
        if (ctrl.measure) begin
            if (ctrl.first) begin
                min_next = pix;
                max_next = pix;
            end else begin
                if (pix < min_reg) min_next = pix;
                if (pix > max_reg) max_next = pix;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= 8'hff;
            max_reg <= 8'h00;
        end else begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    always_comb begin
        dmin = (lo < hi) ? lo : hi;
        dmax = (lo < hi) ? hi : lo;
        if (pix < min_reg)      vc = min_reg;
        else if (pix > max_reg) vc = max_reg;
        else                    vc = pix;
        win     = (pix > lo && pix <= hi) ? pix : 8'd0;
        prod    = a_reg * d_reg;
        shifted = pwa_pkg::NUM_BITS'({8'd0, span_reg, 1'b0} << ctrl.step);
    end

    // operand load, span multiply and restoring divide, one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            dmin_reg <= dmin;
            a_reg    <= vc - min_reg;
            d_reg    <= dmax - dmin;
            span_reg <= max_reg - min_reg;
            flat_reg <= (max_reg <= min_reg);
            win_reg  <= win;
        end
        if (ctrl.mul) begin
            num_reg <= {prod, 1'b0} + {9'd0, span_reg};
            quo_reg <= 8'd0;
        end
        if (ctrl.div && num_reg >= shifted) begin
            num_reg             <= num_reg - shifted;
            quo_reg[ctrl.step]  <= 1'b1;
        end
    end

    always_comb begin
        if (!normalize)    v = win_reg;
        else if (flat_reg) v = dmin_reg;
        else               v = dmin_reg + quo_reg;
        sum = $signed({3'b000, v}) + $signed({{2{offset[8]}}, offset});
        if (!lane_en)                result = 8'd0;
        else if (!bright_en)         result = v;
        else if (sum < 0)            result = 8'd0;
        else if (sum > 11'sd255)     result = 8'hff;
        else                         result = sum[7:0];
    end

endmodule

// File: rtl/pixel_channel_window_adjust_unit.sv
`timescale 1ns / 1ps
// Per-channel pixel adjust on four 8-bit lanes. Measure words (req_type 0)
// return nothing and update each lane's frame min and max; first_of_frame
// restarts them. Apply words (req_type 1) capture their operands at the
// accepting edge and return one word after a span multiply, the per-lane
// restoring divider (one quotient bit a cycle) and a hand-off to the output
// register. The input is ready again right after the hand-off, so no new
// word is taken while an apply word is in flight. The next word is accepted
// as soon as the result sits in the output register, even while it still
// waits for m_ready. Window mode keeps a channel in (low, high], otherwise
// 0; normalize mode maps [min, max] onto the bounds with round half up.
// Brightness saturates at 0 and 255 and skips channels 1 and 2 for HSV and
// HSL. Channels at or above channel_count read 0; a count of zero acts as
// one. Configuration must be written with cfg_wr_en while the block is
// idle; the user must ensure this, as the block does not enforce it.
module pixel_channel_window_adjust_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic        s_first_of_frame,
    input  logic [31:0] s_pixel_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pixel_out
);

    // configuration registers
    logic              normalize_enable_reg;
    logic signed [8:0] brightness_offset_reg;
    logic [1:0]        color_model_reg;
    logic [31:0]       channel_lows_reg;
    logic [31:0]       channel_highs_reg;
    logic [2:0]        channel_count_reg;

    pwa_pkg::pwa_state_t state_reg, state_next;
    logic [pwa_pkg::STEP_BITS-1:0] step_reg, step_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_pixel_out_reg, m_pixel_out_next;

    pwa_pkg::pwa_ctrl_t ctrl;
    logic        accept;
    logic        out_free;
    logic [2:0]  count_eff;
    logic [31:0] lanes_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            normalize_enable_reg  <= 1'b0;
            brightness_offset_reg <= 9'sd0;
            color_model_reg       <= 2'd0;
            channel_lows_reg      <= 32'h0000_0000;
            channel_highs_reg     <= 32'hffff_ffff;
            channel_count_reg     <= 3'd3;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pwa_pkg::REG_NORMALIZE_ENABLE:  normalize_enable_reg  <= cfg_wr_data[0];
                pwa_pkg::REG_BRIGHTNESS_OFFSET: brightness_offset_reg <= cfg_wr_data[8:0];
                pwa_pkg::REG_COLOR_MODEL:       color_model_reg       <= cfg_wr_data[1:0];
                pwa_pkg::REG_CHANNEL_LOWS:      channel_lows_reg      <= cfg_wr_data;
                pwa_pkg::REG_CHANNEL_HIGHS:     channel_highs_reg     <= cfg_wr_data;
                pwa_pkg::REG_CHANNEL_COUNT:     channel_count_reg     <= cfg_wr_data[2:0];
                default: ;
            endcase
        end
    end

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // zero channels act as one, anything past the lanes is clamped
    always_comb begin
        if (channel_count_reg == 3'd0)
            count_eff = 3'd1;
        else if (channel_count_reg > 3'(pwa_pkg::MAX_CHANNELS))
            count_eff = 3'(pwa_pkg::MAX_CHANNELS);
        else
            count_eff = channel_count_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            pwa_pkg::ST_IDLE: begin
                if (accept && s_req_type == pwa_pkg::REQ_APPLY)
                    state_next = pwa_pkg::ST_MUL;
            end
            pwa_pkg::ST_MUL: begin
                state_next = pwa_pkg::ST_DIV;
                step_next  = '1;
            end
            pwa_pkg::ST_DIV: begin
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                    state_next = pwa_pkg::ST_DONE;
            end
            pwa_pkg::ST_DONE: begin
                if (out_free)
                    state_next = pwa_pkg::ST_IDLE;
            end
            default: state_next = pwa_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready      = (state_reg == pwa_pkg::ST_IDLE);
        ctrl.measure = accept && s_req_type == pwa_pkg::REQ_MEASURE;
        ctrl.first   = s_first_of_frame;
        ctrl.load    = accept && s_req_type == pwa_pkg::REQ_APPLY;
        ctrl.mul     = (state_reg == pwa_pkg::ST_MUL);
        ctrl.div     = (state_reg == pwa_pkg::ST_DIV);
        ctrl.step    = step_reg;
    end

    // channel lanes
    for (genvar i = 0; i < pwa_pkg::MAX_CHANNELS; i++) begin : g_lane
        localparam int LO = i * pwa_pkg::CHANNEL_BITS;
        logic bright_en;
        assign bright_en = !((color_model_reg == pwa_pkg::MODEL_HSV ||
                              color_model_reg == pwa_pkg::MODEL_HSL) && (i == 1 || i == 2));
        pwa_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .pix       (s_pixel_in[LO +: 8]),
            .lo        (channel_lows_reg[LO +: 8]),
            .hi        (channel_highs_reg[LO +: 8]),
            .normalize (normalize_enable_reg),
            .offset    (brightness_offset_reg),
            .bright_en (bright_en),
            .lane_en   (3'(i) < count_eff),
            .result    (lanes_word[LO +: 8])
        );
    end

    // output register merges the lanes
    always_comb begin
        m_valid_next     = m_valid_reg;
        m_pixel_out_next = m_pixel_out_reg;
        if (m_valid_reg && m_ready)
            m_valid_next = 1'b0;
        if (state_reg == pwa_pkg::ST_DONE && out_free) begin
            m_valid_next     = 1'b1;
            m_pixel_out_next = lanes_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pwa_pkg::ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_pixel_out_reg <= m_pixel_out_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_pixel_out = m_pixel_out_reg;

`ifndef SYNTHESIS
    // an apply word blocks the input until its result is handed over
    a_apply_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_req_type == pwa_pkg::REQ_APPLY |=> !s_ready)
        else $error("input still ready after apply word");

    // a measure word never starts the divider
    a_measure_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_req_type == pwa_pkg::REQ_MEASURE |=> state_reg == pwa_pkg::ST_IDLE)
        else $error("measure word left idle");

    // last divide step leads to hand-off
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pwa_pkg::ST_DIV && step_reg == '0 |=> state_reg == pwa_pkg::ST_DONE)
        else $error("divider did not finish");
`endif

endmodule

// File: sim/pwa_checker.sv
`timescale 1ns / 1ps
module pwa_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_req_type,
    input  logic        s_first_of_frame,
    input  logic [31:0] s_pixel_in,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_pixel_out,
    output int          fail_count,
    output int          pending_words,
    output int          result_count
);

    logic        norm_en;
    logic [8:0]  bright_off;
    logic [1:0]  model;
    logic [31:0] lows;
    logic [31:0] highs;
    logic [2:0]  chan_count;
    logic [7:0]  fmin [pwa_pkg::MAX_CHANNELS];
    logic [7:0]  fmax [pwa_pkg::MAX_CHANNELS];
    logic [31:0] expected_pixels [$];

    function automatic logic [7:0] scale_lane(logic [7:0] v, logic [7:0] lo, logic [7:0] hi,
                                              logic [7:0] smin, logic [7:0] smax);
        int dmin;
        int dmax;
        int x;
        int span;
        dmin = (lo < hi) ? lo : hi;
        dmax = (lo < hi) ? hi : lo;
        if (smax <= smin) return dmin[7:0];
        x = v;
        if (x < smin) x = smin;
        if (x > smax) x = smax;
        span = smax - smin;
        x = dmin + (2 * (x - smin) * (dmax - dmin) + span) / (2 * span);
        return x[7:0];
    endfunction

    function automatic logic [31:0] adjust_pixel(logic [31:0] pix);
        int          n;
        int          off;
        int          r;
        logic [7:0]  v;
        logic [31:0] res;
        res = '0;
        n = chan_count;
        if (n < 1) n = 1;
        if (n > pwa_pkg::MAX_CHANNELS) n = pwa_pkg::MAX_CHANNELS;
        off = $signed(bright_off);
        for (int i = 0; i < n; i++) begin
            v = pix[i*8 +: 8];
            if (norm_en)
                v = scale_lane(v, lows[i*8 +: 8], highs[i*8 +: 8], fmin[i], fmax[i]);
            else if (!(v > lows[i*8 +: 8] && v <= highs[i*8 +: 8]))
                v = 8'd0;
            if (!((model == pwa_pkg::MODEL_HSV || model == pwa_pkg::MODEL_HSL) &&
                  (i == 1 || i == 2))) begin
                r = int'(v) + off;
                if (r < 0) r = 0;
                if (r > 255) r = 255;
                v = r[7:0];
            end
            res[i*8 +: 8] = v;
        end
        return res;
    endfunction

    assign pending_words = expected_pixels.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            norm_en    <= 1'b0;
            bright_off <= '0;
            model      <= pwa_pkg::MODEL_HSV;
            lows       <= '0;
            highs      <= '1;
            chan_count <= 3'd3;
            for (int i = 0; i < pwa_pkg::MAX_CHANNELS; i++) begin
                fmin[i] = 8'hff;
                fmax[i] = 8'h00;
            end
            fail_count   <= 0;
            result_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    pwa_pkg::REG_NORMALIZE_ENABLE: begin
                        norm_en <= cfg_wr_data[0];
                    end
                    pwa_pkg::REG_BRIGHTNESS_OFFSET: begin
                        bright_off <= cfg_wr_data[8:0];
                    end
                    pwa_pkg::REG_COLOR_MODEL: begin
                        model <= cfg_wr_data[1:0];
                    end
                    pwa_pkg::REG_CHANNEL_LOWS: begin
                        lows <= cfg_wr_data;
                    end
                    pwa_pkg::REG_CHANNEL_HIGHS: begin
                        highs <= cfg_wr_data;
                    end
                    pwa_pkg::REG_CHANNEL_COUNT: begin
                        chan_count <= cfg_wr_data[2:0];
                    end
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_req_type == pwa_pkg::REQ_MEASURE) begin
                    for (int i = 0; i < pwa_pkg::MAX_CHANNELS; i++) begin
                        if (s_first_of_frame || s_pixel_in[i*8 +: 8] < fmin[i])
                            fmin[i] = s_pixel_in[i*8 +: 8];
                        if (s_first_of_frame || s_pixel_in[i*8 +: 8] > fmax[i])
                            fmax[i] = s_pixel_in[i*8 +: 8];
                    end
                end else begin
                    expected_pixels = {expected_pixels, adjust_pixel(s_pixel_in)};
                end
            end
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (expected_pixels.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected word: pixel_out %h", m_pixel_out);
                    fail_count <= fail_count + 1;
                end else if (expected_pixels[0] !== m_pixel_out) begin
                    if (fail_count < 10)
                        $display("pixel_out expected %h actual %h",
                                 expected_pixels[0], m_pixel_out);
                    fail_count <= fail_count + 1;
                    void'(expected_pixels.pop_front());
                end else begin
                    void'(expected_pixels.pop_front());
                end
            end
        end
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;

    localparam int CYCLE_LIMIT = 400000;
    // wait after the last result before reconfig
    localparam int SETTLE_CYCLES = 30;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = 1'b0;
    logic        s_first_of_frame = 1'b0;
    logic [31:0] s_pixel_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_pixel_out;
    int          fail_count;
    int          pending_words;
    int          result_count;
    int          cycle_count = 0;
    int          word_count = 0;
    bit          quiet_tail = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    pixel_channel_window_adjust_unit dut (.*);

    pwa_checker u_checker (.*);

    // watchdog on total run length
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("pixel_channel_window_adjust_unit: mismatch");
            $finish;
        end
    end

    // result side: random stall bursts, none in the tail
    initial begin
        int burst;
        @(posedge aclk);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 10);
                m_ready <= 1'b0;
                repeat (burst) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // one word through the input handshake, with an optional idle burst first
    task automatic send_word(logic req, logic first, logic [31:0] pix);
        int burst;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (burst) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_req_type       <= req;
        s_first_of_frame <= first;
        s_pixel_in       <= pix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        word_count++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic setup(logic norm, logic [8:0] off, logic [1:0] cm,
                         logic [31:0] lo, logic [31:0] hi, logic [2:0] cnt);
        cfg_write(pwa_pkg::REG_NORMALIZE_ENABLE, {31'd0, norm});
        cfg_write(pwa_pkg::REG_BRIGHTNESS_OFFSET, {23'd0, off});
        cfg_write(pwa_pkg::REG_COLOR_MODEL, {30'd0, cm});
        cfg_write(pwa_pkg::REG_CHANNEL_LOWS, lo);
        cfg_write(pwa_pkg::REG_CHANNEL_HIGHS, hi);
        cfg_write(pwa_pkg::REG_CHANNEL_COUNT, {29'd0, cnt});
    endtask

    // bytes clustered near the extremes a quarter of the time
    function automatic logic [31:0] rand_pixel();
        logic [31:0] p;
        p = $urandom;
        for (int i = 0; i < 4; i++)
            if ($urandom_range(0, 3) == 0)
                p[i*8 +: 8] = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                                   : 8'($urandom_range(252, 255));
        return p;
    endfunction

    // a frame: measure pass then an apply pass, plus a little noise
    task automatic run_frame(int len);
        logic [31:0] px;
        for (int i = 0; i < len; i++)
            send_word(pwa_pkg::REQ_MEASURE, i == 0 || $urandom_range(0, 30) == 0,
                      rand_pixel());
        for (int i = 0; i < len; i++) begin
            px = ($urandom_range(0, 9) == 0) ? rand_pixel() : rand_pixel();
            send_word(pwa_pkg::REQ_APPLY, 1'($urandom_range(0, 1)), px);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset config, window edges, all-zero and all-one pixels
        send_word(pwa_pkg::REQ_APPLY, 1'b0, 32'h0000_0000);
        send_word(pwa_pkg::REQ_APPLY, 1'b1, 32'hffff_ffff);
        drain();
        setup(1'b0, 9'd0, 2'd2, 32'h10_10_10_10, 32'h20_20_20_20, 3'd4);
        send_word(pwa_pkg::REQ_APPLY, 1'b0, 32'h10_11_20_21);
        send_word(pwa_pkg::REQ_APPLY, 1'b0, 32'h0f_1f_ff_00);
        drain();
        // max offset, hsv skip, zero channel count
        setup(1'b0, 9'd255, 2'd0, 32'h0, 32'hffff_ffff, 3'd0);
        send_word(pwa_pkg::REQ_APPLY, 1'b0, 32'h0102_0304);
        drain();
        cfg_write(pwa_pkg::REG_CHANNEL_COUNT, 32'd7);
        cfg_write(pwa_pkg::REG_COLOR_MODEL, 32'd1);
        send_word(pwa_pkg::REQ_APPLY, 1'b0, 32'h0102_0304);
        drain();
        // -256 offset, model 3, swapped bounds in normalize, empty span
        setup(1'b1, 9'h100, 2'd3, 32'hff_00_c8_00, 32'h00_ff_32_ff, 3'd4);
        send_word(pwa_pkg::REQ_APPLY, 1'b0, 32'h8080_8080);
        drain();
        cfg_write(pwa_pkg::REG_BRIGHTNESS_OFFSET, 32'h101);
        send_word(pwa_pkg::REQ_MEASURE, 1'b1, 32'h4040_4040);
        send_word(pwa_pkg::REQ_APPLY, 1'b0, 32'h8080_8080);
        send_word(pwa_pkg::REQ_MEASURE, 1'b0, 32'h00ff_10f0);
        send_word(pwa_pkg::REQ_MEASURE, 1'b0, 32'hff00_f010);
        send_word(pwa_pkg::REQ_APPLY, 1'b0, 32'h0000_0000);
        send_word(pwa_pkg::REQ_APPLY, 1'b0, 32'hffff_ffff);
        send_word(pwa_pkg::REQ_APPLY, 1'b1, 32'h7f80_817e);
        drain();

        // random phases, config re-rolled between phases
        for (int ph = 0; ph < 24; ph++) begin
            setup(1'($urandom_range(0, 1)), 9'($urandom), 2'($urandom_range(0, 3)),
                  $urandom, ($urandom_range(0, 3) == 0) ? 32'hffff_ffff : $urandom,
                  3'($urandom_range(0, 7)));
            if (ph == 5) setup(1'b1, 9'h0ff, 2'd2, 32'h0, 32'hffff_ffff, 3'd4);
            if (ph == 6) setup(1'b0, 9'h100, 2'd2, 32'h0, 32'h0, 3'd1);
            if (ph == 20) quiet_tail = 1'b1;
            run_frame($urandom_range(4, 14));
            // a random stream of mixed words too
            for (int i = 0; i < 4; i++)
                send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_pixel());
            if (ph == 10) begin
                // hold off the sender until everything is back
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_words != 0) @(posedge aclk);
            end
            drain();
        end

        drain();
        $display("ran %0d words, %0d results, window and normalize modes", word_count,
                 result_count);
        $display("covered all color models, offset extremes and channel counts 0 to 7");
        if (fail_count == 0)
            $display("pixel_channel_window_adjust_unit: match");
        else
            $display("pixel_channel_window_adjust_unit: mismatch");
        $finish;
    end

endmodule
